>>> hw/rtl/buddy_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// buddy allocator assertion macros
// property forms used by the allocator back end
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bba assertion failed");

// consequent must hold in the cycle after the antecedent
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bba assertion failed");

`endif

>>> hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared constants, types and helpers of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int RegionBits = 20;
  localparam int MinBits    = 5;
  localparam int Orders     = RegionBits - MinBits + 1;
  localparam int OrdW       = 4;
  localparam int AddrW      = 20;
  localparam int SizeW      = 21;
  localparam int HdrW       = 7;
  localparam int HeapW      = Orders;
  localparam int SlotW      = Orders - 1;
  localparam int FmDepth    = (1 << HeapW) / 32;
  localparam int SumDepth   = FmDepth / 32;
  localparam int SlotDepth  = 1 << SlotW;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_OOM = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [HdrW-1:0] HDR_RESET = 7'd24;

  typedef struct packed {
    logic             is_free;
    logic             bad;
    logic [OrdW-1:0]  ord;
    logic [AddrW-1:0] off;
  } bba_job_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } bba_back_stat_t;

  // lowest set bit: {found, index}
  function automatic logic [5:0] first_set32(input logic [31:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, 5'(i)};
      end
    end
    return r;
  endfunction

  // number of significant bits
  function automatic logic [4:0] bit_len20(input logic [19:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 20; i++) begin
      if (v[i]) begin
        n = 5'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

>>> hw/rtl/bba_req_if.sv
// ----------------------------------------------------------------------------
// bba_req_if
// request channel of the buddy allocator
// ----------------------------------------------------------------------------
interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [20:0] req_size;
  logic [19:0] address;

  modport source (output valid, action, req_size, address, input ready);
  modport sink (input valid, action, req_size, address, output ready);
endinterface

>>> hw/rtl/bba_rsp_if.sv
// ----------------------------------------------------------------------------
// bba_rsp_if
// result channel of the buddy allocator
// ----------------------------------------------------------------------------
interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [19:0] address_out;
  logic [1:0]  status;
  logic [3:0]  granted_order;

  modport source (output valid, address_out, status, granted_order, input ready);
  modport sink (input valid, address_out, status, granted_order, output ready);
endinterface

>>> hw/rtl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// power-of-two buddy allocator over a 1 MiB region, 32-byte minimum blocks
// ----------------------------------------------------------------------------
//  port      dir   what
//  in_chan   in    request: action, req_size, address
//  out_chan  out   result: address_out, status, granted_order
//  cfg_*     in    header_bytes write
//
// allocate: a scan of up to 32 summary words, then the bit writes:
//   one bit write plus one per split, each a read-modify-write of the free map
// free: a slot lookup and one bit write, then up to 15 merge levels; a rejected request goes straight to the result
// after reset a clearing pass over the free map, summary and slot tables runs before requests are taken
// a two-entry queue lets requests enter while the result register is stalled
module buddy_block_allocator (
  input  logic       clk,
  input  logic       rst_n,
  bba_req_if.sink    in_chan,
  bba_rsp_if.source  out_chan,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);
  import bba_pkg::*;

  logic [HdrW-1:0] hdr_r;
  logic            q_push, q_pop, q_empty, q_full;
  bba_job_t        f_job, q_head;
  bba_back_stat_t  stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= HDR_RESET;
    end else if (cfg_we) begin
      hdr_r <= cfg_wdata;
    end
  end

  bba_front u_front (
    .in_chan, .hdr(hdr_r), .q_full, .stat, .q_push, .job(f_job)
  );

  bba_queue u_queue (
    .clk, .rst_n, .push(q_push), .din(f_job), .pop(q_pop), .empty(q_empty), .full(q_full),
    .head(q_head)
  );

  bba_back u_back (
    .clk, .rst_n, .hdr(hdr_r), .q_empty, .q_head, .q_pop, .stat, .out_chan
  );
endmodule

>>> hw/rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// generic one write, one read port ram with registered read data
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/bba_front.sv
// ----------------------------------------------------------------------------
// bba_front
// accepts requests and classifies them: order, offset and early rejects
// ----------------------------------------------------------------------------
module bba_front (
  bba_req_if.sink              in_chan,
  input  logic [6:0]           hdr,
  input  logic                 q_full,
  input  bba_pkg::bba_back_stat_t stat,
  output logic                 q_push,
  output bba_pkg::bba_job_t    job
);
  import bba_pkg::*;

  logic [21:0]      total;
  logic [19:0]      total_m1;
  logic [4:0]       blen;
  logic             size_bad;
  logic [AddrW-1:0] off;
  logic             free_bad;

  assign in_chan.ready = !q_full && !stat.clearing;
  assign q_push        = in_chan.valid && in_chan.ready;

  always_comb begin
    total    = {1'b0, in_chan.req_size} + {15'd0, hdr};
    size_bad = (in_chan.req_size == '0) || (total > (22'd1 << RegionBits));
    total_m1 = 20'(total - 22'd1);
    blen     = bit_len20(total_m1);
    off      = in_chan.address - {13'd0, hdr};
    free_bad = ({13'd0, hdr} > in_chan.address) || (off[MinBits-1:0] != '0);

    job.is_free = (in_chan.action == ACT_FREE);
    job.off     = off;
    if (in_chan.action == ACT_FREE) begin
      job.bad = free_bad;
      job.ord = '0;
    end else begin
      job.bad = size_bad;
      // smallest order whose block holds the request plus header
      job.ord = (blen > 5'(MinBits)) ? 4'(blen - 5'(MinBits)) : '0;
    end
  end
endmodule

>>> hw/rtl/bba_queue.sv
// ----------------------------------------------------------------------------
// bba_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module bba_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bba_pkg::bba_job_t din,
  input  logic              pop,
  output logic              empty,
  output logic              full,
  output bba_pkg::bba_job_t head
);
  import bba_pkg::*;

  bba_job_t   ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= din;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> hw/rtl/bba_back.sv
// ----------------------------------------------------------------------------
// bba_back
// executes allocate and free requests on the free map and slot table
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_defines.svh"

module bba_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [6:0]              hdr,
  input  logic                    q_empty,
  input  bba_pkg::bba_job_t       q_head,
  output logic                    q_pop,
  output bba_pkg::bba_back_stat_t stat,
  bba_rsp_if.source               out_chan
);
  import bba_pkg::*;

  typedef enum logic [19:0] {
    S_CLEAR   = 20'h00001,
    S_IDLE    = 20'h00002,
    S_A_START = 20'h00004,
    S_A_SRD   = 20'h00008,
    S_A_SCK   = 20'h00010,
    S_A_WRD   = 20'h00020,
    S_A_WCK   = 20'h00040,
    S_A_SPLIT = 20'h00080,
    S_A_FIN   = 20'h00100,
    S_F_SRD   = 20'h00200,
    S_F_SCK   = 20'h00400,
    S_F_LOOP  = 20'h00800,
    S_F_BRD   = 20'h01000,
    S_F_BCK   = 20'h02000,
    S_F_M2    = 20'h04000,
    S_F_M3    = 20'h08000,
    S_BW_RD   = 20'h10000,
    S_BW_WR   = 20'h20000,
    S_BW_SW   = 20'h40000,
    S_DONE    = 20'h80000
  } state_t;

  localparam logic [OrdW-1:0] OrdMax = 4'(Orders - 1);

  state_t           state_r;
  state_t           ret_r;
  bba_job_t         job_r;
  logic [SlotW-1:0] clr_r;
  logic [HeapW-1:0] h_r;
  logic [OrdW-1:0]  cur_ord_r;
  logic [5:0]       sw_r;
  logic [10:0]      w_r;
  logic [HeapW-1:0] op_h_r;
  logic             op_val_r;
  logic [OrdW-1:0]  op_ord_r;
  logic             nz_r;
  logic [15:0]      cnt_r [Orders];
  logic [AddrW-1:0] res_addr_r;
  logic [1:0]       res_st_r;
  logic [OrdW-1:0]  res_ord_r;
  logic             out_valid_r;
  logic [AddrW-1:0] out_addr_r;
  logic [1:0]       out_st_r;
  logic [OrdW-1:0]  out_ord_r;

  // ram ports
  logic             fm_we;
  logic [10:0]      fm_waddr, fm_raddr;
  logic [31:0]      fm_wdata, fm_rdata;
  logic             sum_we;
  logic [5:0]       sum_waddr, sum_raddr;
  logic [31:0]      sum_wdata, sum_rdata;
  logic             sl_we;
  logic [SlotW-1:0] sl_waddr, sl_raddr;
  logic [4:0]       sl_wdata, sl_rdata;

  bba_ram #(.Width(32), .Depth(FmDepth)) u_fm (
    .clk, .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata), .raddr(fm_raddr), .rdata(fm_rdata)
  );
  bba_ram #(.Width(32), .Depth(SumDepth)) u_sum (
    .clk, .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata), .raddr(sum_raddr),
    .rdata(sum_rdata)
  );
  bba_ram #(.Width(5), .Depth(SlotDepth)) u_slot (
    .clk, .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata), .raddr(sl_raddr), .rdata(sl_rdata)
  );

  logic [15:0]      avail;
  logic [5:0]       f_pick;
  logic [HeapW-1:0] lo_sel, lo_cur;
  logic [31:0]      smask, wmask;
  logic [5:0]       s_pick, w_pick;
  logic             wck_hit;
  logic             old_bit;
  logic [31:0]      new_word;
  logic [HeapW-1:0] bud;
  logic [HeapW-1:0] idx_lvl;
  logic [AddrW-1:0] a_off;
  logic [HeapW-1:0] f_h;
  logic [OrdW-1:0]  sl_ord;

  assign q_pop         = (state_r == S_IDLE) && !q_empty;
  assign stat.clearing = (state_r == S_CLEAR);
  assign stat.busy     = (state_r != S_IDLE);

  assign out_chan.valid         = out_valid_r;
  assign out_chan.address_out   = out_addr_r;
  assign out_chan.status        = out_st_r;
  assign out_chan.granted_order = out_ord_r;

  always_comb begin
    for (int o = 0; o < Orders; o++) begin
      avail[o] = (cnt_r[o] != '0) && (4'(o) >= job_r.ord);
    end
    f_pick = first_set32({16'd0, avail});
    lo_sel = HeapW'(1) << (OrdMax - f_pick[3:0]);
    lo_cur = HeapW'(1) << (OrdMax - cur_ord_r);

    // summary bits and free-map bits of words that belong to the current level
    for (int b = 0; b < 32; b++) begin
      smask[b] = ({sw_r, 5'(b)} >= lo_cur[15:5]) &&
                 ({1'b0, sw_r, 5'(b)} < {lo_cur[15:5], 1'b0});
      wmask[b] = ({w_r, 5'(b)} >= lo_cur) &&
                 ({1'b0, w_r, 5'(b)} < {lo_cur, 1'b0});
    end
    s_pick  = first_set32(sum_rdata & smask);
    w_pick  = first_set32(fm_rdata & wmask);
    wck_hit = w_pick[5];

    old_bit  = fm_rdata[op_h_r[4:0]];
    new_word = fm_rdata;
    new_word[op_h_r[4:0]] = op_val_r;

    bud     = h_r ^ HeapW'(1);
    idx_lvl = h_r - lo_cur;
    a_off   = AddrW'(idx_lvl) << (5'(cur_ord_r) + 5'(MinBits));

    sl_ord = sl_rdata[3:0];
    f_h    = (HeapW'(1) << (OrdMax - sl_ord)) +
             HeapW'(job_r.off >> (5'(sl_ord) + 5'(MinBits)));
  end

  always_comb begin
    fm_we     = 1'b0;
    fm_waddr  = op_h_r[15:5];
    fm_wdata  = new_word;
    fm_raddr  = op_h_r[15:5];
    sum_we    = 1'b0;
    sum_waddr = op_h_r[15:10];
    sum_wdata = sum_rdata;
    sum_wdata[op_h_r[9:5]] = nz_r;
    sum_raddr = op_h_r[15:10];
    sl_we     = 1'b0;
    sl_waddr  = a_off[19:5];
    sl_wdata  = {1'b1, cur_ord_r};
    sl_raddr  = job_r.off[19:5];
    case (state_r)
      S_CLEAR: begin
        fm_we     = (clr_r[14:11] == '0);
        fm_waddr  = clr_r[10:0];
        fm_wdata  = (clr_r[10:0] == '0) ? 32'h2 : 32'h0;
        sum_we    = (clr_r[14:6] == '0);
        sum_waddr = clr_r[5:0];
        sum_wdata = (clr_r[5:0] == '0) ? 32'h1 : 32'h0;
        sl_we     = 1'b1;
        sl_waddr  = clr_r;
        sl_wdata  = '0;
      end
      S_A_SRD: sum_raddr = sw_r;
      S_A_WRD: fm_raddr = w_r;
      S_A_FIN: sl_we = 1'b1;
      S_F_SCK: begin
        sl_we    = sl_rdata[4];
        sl_waddr = job_r.off[19:5];
        sl_wdata = {1'b0, sl_ord};
      end
      S_F_BRD: fm_raddr = bud[15:5];
      S_BW_WR: fm_we = 1'b1;
      S_BW_SW: sum_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int o = 0; o < Orders; o++) begin
        cnt_r[o] <= (o == Orders - 1) ? 16'd1 : 16'd0;
      end
    end else begin
      if (out_chan.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            job_r      <= q_head;
            res_addr_r <= '0;
            res_st_r   <= ST_BAD;
            res_ord_r  <= '0;
            if (q_head.bad) begin
              state_r <= S_DONE;
            end else if (q_head.is_free) begin
              state_r <= S_F_SRD;
            end else begin
              state_r <= S_A_START;
            end
          end
        end
        S_A_START: begin
          cur_ord_r <= f_pick[3:0];
          w_r       <= '0;
          sw_r      <= lo_sel[15:10];
          if (!f_pick[5]) begin
            res_st_r <= ST_OOM;
            state_r  <= S_DONE;
          end else if (f_pick[3:0] > OrdMax - 4'(MinBits)) begin
            // shallow levels all live in word zero
            state_r <= S_A_WRD;
          end else begin
            state_r <= S_A_SRD;
          end
        end
        S_A_SRD: state_r <= S_A_SCK;
        S_A_SCK: begin
          if (s_pick[5]) begin
            w_r     <= {sw_r, s_pick[4:0]};
            state_r <= S_A_WRD;
          end else begin
            sw_r    <= sw_r + 1'b1;
            state_r <= S_A_SRD;
          end
        end
        S_A_WRD: state_r <= S_A_WCK;
        S_A_WCK: begin
          h_r      <= {w_r, w_pick[4:0]};
          op_h_r   <= {w_r, w_pick[4:0]};
          op_val_r <= 1'b0;
          op_ord_r <= cur_ord_r;
          ret_r    <= S_A_SPLIT;
          state_r  <= S_BW_RD;
        end
        S_A_SPLIT: begin
          if (cur_ord_r > job_r.ord) begin
            // upper half goes free, keep splitting the lower half
            op_h_r    <= {h_r[14:0], 1'b1};
            op_val_r  <= 1'b1;
            op_ord_r  <= cur_ord_r - 1'b1;
            h_r       <= {h_r[14:0], 1'b0};
            cur_ord_r <= cur_ord_r - 1'b1;
            ret_r     <= S_A_SPLIT;
            state_r   <= S_BW_RD;
          end else begin
            state_r <= S_A_FIN;
          end
        end
        S_A_FIN: begin
          res_addr_r <= a_off + {13'd0, hdr};
          res_st_r   <= ST_OK;
          res_ord_r  <= cur_ord_r;
          state_r    <= S_DONE;
        end
        S_F_SRD: state_r <= S_F_SCK;
        S_F_SCK: begin
          if (!sl_rdata[4]) begin
            state_r <= S_DONE;
          end else begin
            res_st_r  <= ST_OK;
            res_ord_r <= sl_ord;
            cur_ord_r <= sl_ord;
            h_r       <= f_h;
            op_h_r    <= f_h;
            op_val_r  <= 1'b1;
            op_ord_r  <= sl_ord;
            ret_r     <= S_F_LOOP;
            state_r   <= S_BW_RD;
          end
        end
        S_F_LOOP: state_r <= (h_r == HeapW'(1)) ? S_DONE : S_F_BRD;
        S_F_BRD: state_r <= S_F_BCK;
        S_F_BCK: begin
          if (!fm_rdata[bud[4:0]]) begin
            state_r <= S_DONE;
          end else begin
            op_h_r   <= h_r;
            op_val_r <= 1'b0;
            op_ord_r <= cur_ord_r;
            ret_r    <= S_F_M2;
            state_r  <= S_BW_RD;
          end
        end
        S_F_M2: begin
          op_h_r   <= bud;
          op_val_r <= 1'b0;
          op_ord_r <= cur_ord_r;
          ret_r    <= S_F_M3;
          state_r  <= S_BW_RD;
        end
        S_F_M3: begin
          h_r       <= h_r >> 1;
          cur_ord_r <= cur_ord_r + 1'b1;
          op_h_r    <= h_r >> 1;
          op_val_r  <= 1'b1;
          op_ord_r  <= cur_ord_r + 1'b1;
          ret_r     <= S_F_LOOP;
          state_r   <= S_BW_RD;
        end
        S_BW_RD: state_r <= S_BW_WR;
        S_BW_WR: begin
          nz_r <= (new_word != '0);
          if (old_bit != op_val_r) begin
            cnt_r[op_ord_r] <= op_val_r ? cnt_r[op_ord_r] + 1'b1 : cnt_r[op_ord_r] - 1'b1;
          end
          state_r <= S_BW_SW;
        end
        S_BW_SW: state_r <= ret_r;
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_addr_r  <= res_addr_r;
            out_st_r    <= res_st_r;
            out_ord_r   <= res_ord_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BBA_ASSERT_SAME(a_level_found, clk, rst_n, state_r == S_A_WCK, wck_hit)
  `BBA_ASSERT_SAME(a_bit_changes, clk, rst_n, state_r == S_BW_WR, old_bit != op_val_r)
  `BBA_ASSERT_SAME(a_split_order, clk, rst_n, state_r == S_A_FIN, cur_ord_r == job_r.ord)
  `BBA_ASSERT_NEXT(a_pop_leaves_idle, clk, rst_n, q_pop, state_r != S_IDLE)
endmodule
